// ===== rtl/sm3_pkg.sv =====
// ----------------------------------------------------------------------------
// sm3_pkg
// shared types, constants and round functions of the sm3 hash engine
// ----------------------------------------------------------------------------
package sm3_pkg;

  localparam int WordW    = 32;
  localparam int BlkWords = 16;
  localparam int CvWords  = 8;

  typedef logic [BlkWords-1:0][WordW-1:0] blk_t;
  typedef logic [CvWords-1:0][WordW-1:0]  cv_t;

  localparam cv_t SM3_IV = {
    32'hB0FB0E4E, 32'hE38DEE4D, 32'h163138AA, 32'hA96F30BC,
    32'hDA8A0600, 32'h172442D7, 32'h4914B2B9, 32'h7380166F
  };

  localparam logic [WordW-1:0] T_LOW  = 32'h79CC4519;
  localparam logic [WordW-1:0] T_HIGH = 32'h7A879D8A;
  localparam logic [7:0]       PAD_BYTE = 8'h80;
  localparam logic [5:0]       LEN_FILL = 6'd56;

  typedef enum logic [7:0] {
    S_IDLE  = 8'b0000_0001,
    S_DATA  = 8'b0000_0010,
    S_PAD80 = 8'b0000_0100,
    S_PADZ  = 8'b0000_1000,
    S_LEN   = 8'b0001_0000,
    S_CLOAD = 8'b0010_0000,
    S_COMP  = 8'b0100_0000,
    S_OUT   = 8'b1000_0000
  } state_t;

  function automatic logic [WordW-1:0] rotl(input logic [WordW-1:0] x,
                                            input logic [4:0] n);
    logic [2*WordW-1:0] d;
    d = {x, x} << n;
    return d[2*WordW-1:WordW];
  endfunction

  function automatic logic [WordW-1:0] perm0(input logic [WordW-1:0] x);
    return x ^ rotl(x, 5'd9) ^ rotl(x, 5'd17);
  endfunction

  function automatic logic [WordW-1:0] perm1(input logic [WordW-1:0] x);
    return x ^ rotl(x, 5'd15) ^ rotl(x, 5'd23);
  endfunction

endpackage

// ===== rtl/sm3_round.sv =====
// ----------------------------------------------------------------------------
// sm3_round
// compression unit: the 64 sm3 rounds, one round per cycle, run in back-to-back cycles
// ----------------------------------------------------------------------------
module sm3_round (
  input  logic         clk,
  input  logic         rst_n,
  input  logic         start_i,
  input  sm3_pkg::blk_t blk_i,
  input  sm3_pkg::cv_t  cv_i,
  output logic         done_o,
  output sm3_pkg::cv_t  v_o
);

  sm3_pkg::cv_t  v_r, v_nxt;
  sm3_pkg::blk_t w_r, w_nxt;
  logic [5:0]    j_r;
  logic          run_r;
  logic          done_r;

  logic [31:0] tj, a12, ss1, ss2, ff, gg, tt1, tt2, nw;

  always_comb begin
    tj  = (j_r < 6'd16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
    a12 = sm3_pkg::rotl(v_r[0], 5'd12);
    ss1 = sm3_pkg::rotl(a12 + v_r[4] + sm3_pkg::rotl(tj, j_r[4:0]), 5'd7);
    ss2 = ss1 ^ a12;
    if (j_r < 6'd16) begin
      ff = v_r[0] ^ v_r[1] ^ v_r[2];
      gg = v_r[4] ^ v_r[5] ^ v_r[6];
    end else begin
      ff = (v_r[0] & v_r[1]) | (v_r[0] & v_r[2]) | (v_r[1] & v_r[2]);
      gg = (v_r[4] & v_r[5]) | (~v_r[4] & v_r[6]);
    end
    tt1 = ff + v_r[3] + ss2 + (w_r[0] ^ w_r[4]);
    tt2 = gg + v_r[7] + ss1 + w_r[0];
    // window slides by one word, w_r[0] is W[j]
    nw = sm3_pkg::perm1(w_r[0] ^ w_r[7] ^ sm3_pkg::rotl(w_r[13], 5'd15))
         ^ sm3_pkg::rotl(w_r[3], 5'd7) ^ w_r[10];

    v_nxt[3] = v_r[2];
    v_nxt[2] = sm3_pkg::rotl(v_r[1], 5'd9);
    v_nxt[1] = v_r[0];
    v_nxt[0] = tt1;
    v_nxt[7] = v_r[6];
    v_nxt[6] = sm3_pkg::rotl(v_r[5], 5'd19);
    v_nxt[5] = v_r[4];
    v_nxt[4] = sm3_pkg::perm0(tt2);

    for (int k = 0; k < sm3_pkg::BlkWords - 1; k++) begin
      w_nxt[k] = w_r[k+1];
    end
    w_nxt[sm3_pkg::BlkWords-1] = nw;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      run_r  <= 1'b0;
      done_r <= 1'b0;
      j_r    <= '0;
    end else begin
      done_r <= 1'b0;
      if (start_i) begin
        run_r <= 1'b1;
        j_r   <= '0;
      end else if (run_r) begin
        j_r <= j_r + 6'd1;
        if (j_r == 6'd63) begin
          run_r  <= 1'b0;
          done_r <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (start_i) begin
      v_r <= cv_i;
      w_r <= blk_i;
    end else if (run_r) begin
      v_r <= v_nxt;
      w_r <= w_nxt;
    end
  end

  assign done_o = done_r;
  assign v_o    = v_r;

endmodule

// ===== rtl/sm3_hash_engine_top.sv =====
// ----------------------------------------------------------------------------
// sm3_hash_engine_top
// sm3 hash over a stream of big-endian words, 256-bit digest as 8 transfers
// ----------------------------------------------------------------------------
// data path: a word is taken in idle, then its bytes go into the block buffer
//   one per cycle, held while a full block is compressed; each full block goes
//   to the round unit for a load step, 64 rounds and a fold of the result into
//   the chaining value
// last word: padding goes in at one byte a cycle (held the same way), with
//   the length last; one or two compressions follow, then 8 digest transfers
// reset: synchronous active-low rst_n, chaining value back to the iv, byte
//   fill and bit count cleared; no sweep, ready in the cycle after reset
module sm3_hash_engine_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [31:0] in_data_word,
  input  logic [2:0]  in_byte_count,
  input  logic        in_last,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_digest_word,
  output logic [2:0]  out_word_index,
  output logic        out_last_word
);

  sm3_pkg::state_t state_r, state_nxt, ret_r, follow;

  sm3_pkg::cv_t  cv_r;
  sm3_pkg::blk_t blk_r;
  logic [5:0]    fill_r;      // bytes held in the block buffer
  logic [63:0]   bitlen_r;    // message bit count, shifted out during length
  logic [31:0]   word_r;      // current input word, top byte next
  logic [2:0]    cnt_r;       // bytes of word_r still to pack
  logic          last_r;
  logic [2:0]    lcnt_r;      // length byte counter
  logic [2:0]    oidx_r;      // digest word counter

  logic          push_en;
  logic [7:0]    push_byte;
  logic [5:0]    fill_inc;
  logic          wrap;
  logic [2:0]    cnt_eff;
  logic [31:0]   wr_word;
  logic          in_xfer, out_xfer;

  logic          cu_start, cu_done;
  sm3_pkg::cv_t  cu_v;

  // byte count above four counts as a full word
  assign cnt_eff  = in_byte_count[2] ? 3'd4 : in_byte_count;
  assign in_ready = (state_r == sm3_pkg::S_IDLE);
  assign in_xfer  = in_valid && in_ready;
  assign out_valid = (state_r == sm3_pkg::S_OUT);
  assign out_xfer  = out_valid && out_ready;

  assign out_digest_word = cv_r[oidx_r];
  assign out_word_index  = oidx_r;
  assign out_last_word   = (oidx_r == 3'd7);

  assign push_en = (state_r == sm3_pkg::S_DATA) || (state_r == sm3_pkg::S_PAD80) ||
                   (state_r == sm3_pkg::S_PADZ) || (state_r == sm3_pkg::S_LEN);
  assign fill_inc = fill_r + 6'd1;
  assign wrap     = push_en && (fill_r == 6'd63);
  assign cu_start = (state_r == sm3_pkg::S_CLOAD);

  // byte source for the current state
  always_comb begin
    unique case (state_r)
      sm3_pkg::S_DATA:  push_byte = word_r[31:24];
      sm3_pkg::S_PAD80: push_byte = sm3_pkg::PAD_BYTE;
      sm3_pkg::S_LEN:   push_byte = bitlen_r[63:56];
      default:          push_byte = 8'h00;
    endcase
  end

  // word of the block buffer with the new byte merged in; a fresh word
  // starts from zero
  always_comb begin
    wr_word = (fill_r[1:0] == 2'd0) ? 32'h0 : blk_r[fill_r[5:2]];
    case (fill_r[1:0])
      2'd0:    wr_word[31:24] = push_byte;
      2'd1:    wr_word[23:16] = push_byte;
      2'd2:    wr_word[15:8]  = push_byte;
      default: wr_word[7:0]   = push_byte;
    endcase
  end

  // where the sequencer goes after this byte, before any compression
  always_comb begin
    unique case (state_r)
      sm3_pkg::S_DATA:
        follow = (cnt_r == 3'd1) ? (last_r ? sm3_pkg::S_PAD80 : sm3_pkg::S_IDLE)
                                 : sm3_pkg::S_DATA;
      sm3_pkg::S_PAD80, sm3_pkg::S_PADZ:
        follow = (fill_inc == sm3_pkg::LEN_FILL) ? sm3_pkg::S_LEN : sm3_pkg::S_PADZ;
      sm3_pkg::S_LEN:
        follow = (lcnt_r == 3'd7) ? sm3_pkg::S_OUT : sm3_pkg::S_LEN;
      default:
        follow = sm3_pkg::S_IDLE;
    endcase
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      sm3_pkg::S_IDLE: begin
        if (in_valid) begin
          if (cnt_eff != 3'd0) begin
            state_nxt = sm3_pkg::S_DATA;
          end else if (in_last) begin
            state_nxt = sm3_pkg::S_PAD80;
          end
        end
      end
      sm3_pkg::S_DATA, sm3_pkg::S_PAD80, sm3_pkg::S_PADZ, sm3_pkg::S_LEN: begin
        state_nxt = wrap ? sm3_pkg::S_CLOAD : follow;
      end
      sm3_pkg::S_CLOAD: state_nxt = sm3_pkg::S_COMP;
      sm3_pkg::S_COMP: begin
        if (cu_done) begin
          state_nxt = ret_r;
        end
      end
      sm3_pkg::S_OUT: begin
        if (out_ready && (oidx_r == 3'd7)) begin
          state_nxt = sm3_pkg::S_IDLE;
        end
      end
      default: state_nxt = sm3_pkg::S_IDLE;
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r  <= sm3_pkg::S_IDLE;
      ret_r    <= sm3_pkg::S_IDLE;
      cv_r     <= sm3_pkg::SM3_IV;
      fill_r   <= '0;
      bitlen_r <= '0;
      lcnt_r   <= '0;
      oidx_r   <= '0;
      cnt_r    <= '0;
      last_r   <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (in_xfer) begin
        cnt_r    <= cnt_eff;
        last_r   <= in_last;
        bitlen_r <= bitlen_r + {58'd0, cnt_eff, 3'd0};
      end
      if (push_en) begin
        fill_r <= fill_inc;
        if (wrap) begin
          ret_r <= follow;
        end
      end
      if (state_r == sm3_pkg::S_DATA) begin
        cnt_r <= cnt_r - 3'd1;
      end
      if (state_r == sm3_pkg::S_LEN) begin
        bitlen_r <= {bitlen_r[55:0], 8'h00};
        lcnt_r   <= lcnt_r + 3'd1;
      end
      // feed-forward of the compressed block
      if ((state_r == sm3_pkg::S_COMP) && cu_done) begin
        for (int k = 0; k < sm3_pkg::CvWords; k++) begin
          cv_r[k] <= cv_r[k] ^ cu_v[k];
        end
      end
      if (out_xfer) begin
        oidx_r <= oidx_r + 3'd1;
        // digest delivered, start over from the iv
        if (oidx_r == 3'd7) begin
          cv_r     <= sm3_pkg::SM3_IV;
          fill_r   <= '0;
          bitlen_r <= '0;
          lcnt_r   <= '0;
        end
      end
    end
  end

  // payload registers
  always_ff @(posedge clk) begin
    if (in_xfer) begin
      word_r <= in_data_word;
    end else if (state_r == sm3_pkg::S_DATA) begin
      word_r <= {word_r[23:0], 8'h00};
    end
    if (push_en) begin
      blk_r[fill_r[5:2]] <= wr_word;
    end
  end

  sm3_round u_round (
    .clk     (clk),
    .rst_n   (rst_n),
    .start_i (cu_start),
    .blk_i   (blk_r),
    .cv_i    (cv_r),
    .done_o  (cu_done),
    .v_o     (cu_v)
  );

  // no input transfer while a digest is being delivered
  a_out_blocks_in: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !in_ready) else $error("input ready during digest output");

  // the round unit only finishes while the sequencer waits for it
  a_done_in_comp: assert property (@(posedge clk) disable iff (!rst_n)
    cu_done |-> (state_r == sm3_pkg::S_COMP)) else $error("round unit done out of place");

  // after the final digest word the engine is back at the iv, empty
  a_restart: assert property (@(posedge clk) disable iff (!rst_n)
    (out_xfer && out_last_word) |=>
      (cv_r == sm3_pkg::SM3_IV && fill_r == 6'd0 && bitlen_r == 64'd0))
    else $error("state not restored after digest");

endmodule

// ===== tb/tb.sv =====
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the sm3 hash engine: directed and random messages,
// digests predicted in the bench and compared word by word
// ----------------------------------------------------------------------------
module tb;

  timeunit 1ns;
  timeprecision 1ps;

  logic        clk;
  logic        rst_n;
  logic        in_valid;
  logic        in_ready;
  logic [31:0] in_data_word;
  logic [2:0]  in_byte_count;
  logic        in_last;
  logic        out_valid;
  logic        out_ready;
  logic [31:0] out_digest_word;
  logic [2:0]  out_word_index;
  logic        out_last_word;

  sm3_hash_engine_top uut (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .in_data_word    (in_data_word),
    .in_byte_count   (in_byte_count),
    .in_last         (in_last),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .out_digest_word (out_digest_word),
    .out_word_index  (out_word_index),
    .out_last_word   (out_last_word)
  );

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  idx;
    logic        fin;
  } digest_beat_t;

  typedef struct packed {
    logic [31:0] word;
    logic [2:0]  cnt;
    logic        fin;
  } msg_word_t;

  // hash state of the bench's own sm3 model
  logic [31:0] hv_cv [8];
  logic [31:0] hv_buf [16];
  int unsigned hv_fill;
  logic [63:0] hv_bits;

  digest_beat_t digest_q [$];
  int           errors;
  bit           idle_free;   // no random gaps while set
  bit           timed_out;

  function automatic logic [31:0] rol(input logic [31:0] x, input int n);
    int m;
    m = n % 32;
    return (m == 0) ? x : ((x << m) | (x >> (32 - m)));
  endfunction

  task automatic hv_init();
    for (int k = 0; k < 8; k++) hv_cv[k] = sm3_pkg::SM3_IV[k];
    for (int k = 0; k < 16; k++) hv_buf[k] = '0;
    hv_fill = 0;
    hv_bits = '0;
  endtask

  task automatic hv_compress();
    logic [31:0] w [68];
    logic [31:0] v [8];
    logic [31:0] a12, ss1, ss2, ff, gg, tt1, tt2, tj;
    for (int k = 0; k < 16; k++) w[k] = hv_buf[k];
    for (int k = 16; k < 68; k++) begin
      w[k] = (w[k-16] ^ w[k-9] ^ rol(w[k-3], 15));
      w[k] = w[k] ^ rol(w[k], 15) ^ rol(w[k], 23) ^ rol(w[k-13], 7) ^ w[k-6];
    end
    for (int k = 0; k < 8; k++) v[k] = hv_cv[k];
    for (int j = 0; j < 64; j++) begin
      tj  = (j < 16) ? sm3_pkg::T_LOW : sm3_pkg::T_HIGH;
      a12 = rol(v[0], 12);
      ss1 = rol(a12 + v[4] + rol(tj, j), 7);
      ss2 = ss1 ^ a12;
      if (j < 16) begin
        ff = v[0] ^ v[1] ^ v[2];
        gg = v[4] ^ v[5] ^ v[6];
      end else begin
        ff = (v[0] & v[1]) | (v[0] & v[2]) | (v[1] & v[2]);
        gg = (v[4] & v[5]) | (~v[4] & v[6]);
      end
      tt1 = ff + v[3] + ss2 + (w[j] ^ w[j+4]);
      tt2 = gg + v[7] + ss1 + w[j];
      v[3] = v[2];
      v[2] = rol(v[1], 9);
      v[1] = v[0];
      v[0] = tt1;
      v[7] = v[6];
      v[6] = rol(v[5], 19);
      v[5] = v[4];
      v[4] = tt2 ^ rol(tt2, 9) ^ rol(tt2, 17);
    end
    for (int k = 0; k < 8; k++) hv_cv[k] ^= v[k];
  endtask

  task automatic hv_byte(input logic [7:0] b);
    int unsigned sh;
    sh = 8 * (3 - (hv_fill % 4));
    if (hv_fill % 4 == 0) hv_buf[hv_fill / 4] = '0;
    hv_buf[hv_fill / 4] |= 32'(b) << sh;
    hv_fill = (hv_fill + 1) % 64;
    if (hv_fill == 0) hv_compress();
  endtask

  // absorb one word; on the end of a message queue the 8 digest words
  task automatic sm3_absorb(input msg_word_t m);
    int unsigned n;
    logic [63:0] len;
    digest_beat_t d;
    n = (m.cnt > 4) ? 4 : m.cnt;
    for (int i = 0; i < n; i++) hv_byte(m.word[31 - 8*i -: 8]);
    hv_bits += 64'(n * 8);
    if (m.fin) begin
      len = hv_bits;
      hv_byte(sm3_pkg::PAD_BYTE);
      while (hv_fill != sm3_pkg::LEN_FILL) hv_byte(8'h00);
      for (int i = 0; i < 8; i++) hv_byte(len[63 - 8*i -: 8]);
      for (int i = 0; i < 8; i++) begin
        d.word = hv_cv[i];
        d.idx  = 3'(i);
        d.fin  = (i == 7);
        digest_q.push_back(d);
      end
      hv_init();
    end
  endtask

  task automatic report_mismatch(input string what, input logic [31:0] got,
                                 input logic [31:0] want);
    $display("mismatch %s: got %h, want %h at %0t", what, got, want, $time);
    errors++;
  endtask

  initial begin
    clk = 1'b0;
    forever #6 clk = ~clk;
  end

  initial begin
    #50ms;
    timed_out = 1'b1;
    $display("[FAIL] regression broken");
    $finish;
  end

  // result side: random stalls, checks each transfer against the oldest digest word
  always @(posedge clk) begin
    digest_beat_t e;
    if (rst_n) begin
      if (out_valid && out_ready) begin
        if (digest_q.size() == 0) begin
          report_mismatch("unexpected digest word", out_digest_word, '0);
        end else begin
          e = digest_q.pop_front();
          if (out_digest_word !== e.word)
            report_mismatch("digest_word", out_digest_word, e.word);
          if (out_word_index !== e.idx)
            report_mismatch("word_index", 32'(out_word_index), 32'(e.idx));
          if (out_last_word !== e.fin)
            report_mismatch("last_word", 32'(out_last_word), 32'(e.fin));
        end
      end
      out_ready <= idle_free || ($urandom_range(99) >= 21);
    end
  end

  // send one word: a random gap first, then hold valid until the transfer
  task automatic send_word(input msg_word_t m);
    while (!idle_free && $urandom_range(99) < 21) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid      <= 1'b1;
    in_data_word  <= m.word;
    in_byte_count <= m.cnt;
    in_last       <= m.fin;
    do @(posedge clk); while (!in_ready);
    sm3_absorb(m);
  endtask

  // whole message of nwords words, mostly full, plus a tail word of tail_cnt bytes
  task automatic send_message(input int nwords, input int tail_cnt);
    msg_word_t m;
    for (int i = 0; i < nwords; i++) begin
      m.word = $urandom();
      m.cnt  = ($urandom_range(99) < 6) ? 3'($urandom_range(7)) : 3'd4;
      m.fin  = 1'b0;
      send_word(m);
    end
    m.word = $urandom();
    m.cnt  = 3'(tail_cnt);
    m.fin  = 1'b1;
    send_word(m);
  endtask

  // directed table: the empty message and "abc" digests are known values
  msg_word_t    dir_tab [13];
  logic [31:0]  abc_dig [8];
  logic [31:0]  nil_dig [8];

  initial begin
    int wait_cycles;
    msg_word_t m;
    errors    = 0;
    idle_free = 1'b0;
    timed_out = 1'b0;
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_data_word  = '0;
    in_byte_count = '0;
    in_last       = 1'b0;
    out_ready     = 1'b0;
    hv_init();

    dir_tab[0]  = '{32'h0000_0000, 3'd0, 1'b1};  // empty message
    dir_tab[1]  = '{32'h6162_63FF, 3'd3, 1'b1};  // "abc"
    dir_tab[2]  = '{32'hFFFF_FFFF, 3'd4, 1'b1};
    dir_tab[3]  = '{32'h0000_0000, 3'd4, 1'b1};
    dir_tab[4]  = '{32'hA5A5_A5A5, 3'd7, 1'b1};  // count above four
    dir_tab[5]  = '{32'h1234_5678, 3'd5, 1'b0};
    dir_tab[6]  = '{32'hDEAD_BEEF, 3'd1, 1'b0};  // short word mid-stream
    dir_tab[7]  = '{32'hCAFE_F00D, 3'd2, 1'b0};
    dir_tab[8]  = '{32'h8000_0001, 3'd6, 1'b1};
    dir_tab[9]  = '{32'h7FFF_FFFE, 3'd4, 1'b0};
    dir_tab[10] = '{32'h0102_0304, 3'd0, 1'b0};  // empty word mid-stream
    dir_tab[11] = '{32'hFEDC_BA98, 3'd3, 1'b0};
    dir_tab[12] = '{32'h5555_AAAA, 3'd0, 1'b1};
    nil_dig = '{32'h1AB21D83, 32'h55CFA17F, 32'h8E611948, 32'h31E81A8F,
                32'h22BEC8C7, 32'h28FEFB74, 32'h7ED035EB, 32'h5082AA2B};
    abc_dig = '{32'h66C7F0F4, 32'h62EEEDD9, 32'hD1F2D46B, 32'hDC10E4E2,
                32'h4167C487, 32'h5CF2F7A2, 32'h297DA02B, 32'h8F4BA8E0};

    repeat (4) @(posedge clk);
    rst_n     <= 1'b1;
    @(posedge clk);

    foreach (dir_tab[r]) begin
      send_word(dir_tab[r]);
      // typed-in digests for the first two rows, model otherwise
      if (r < 2) begin
        for (int i = 0; i < 8; i++)
          digest_q[digest_q.size() - 8 + i].word = (r == 0) ? nil_dig[i] : abc_dig[i];
      end
    end
    // messages whose padding fits the last block or needs one more (55, 56 and 64 bytes when all words are full)
    send_message(13, 3);
    send_message(14, 0);
    send_message(15, 4);

    // hold off until every digest word is back
    in_valid <= 1'b0;
    wait_cycles = 0;
    while (digest_q.size() != 0) @(posedge clk);

    // random messages, mostly short, with a stretch free of gaps
    for (int n = 0; n < 8; n++) begin
      idle_free = (n >= 3 && n < 6);
      send_message(($urandom_range(9) == 0) ? $urandom_range(20, 34)
                                            : $urandom_range(0, 6),
                   $urandom_range(0, 4));
    end
    idle_free = 1'b0;
    in_valid <= 1'b0;

    while (digest_q.size() != 0 && wait_cycles < 200000) begin
      @(posedge clk);
      wait_cycles++;
    end
    repeat (200) @(posedge clk);
    if (!timed_out) begin
      if (errors == 0 && digest_q.size() == 0) begin
        $display("[ OK ] regression clean");
      end else begin
        $display("[FAIL] regression broken");
      end
      $finish;
    end
  end

endmodule

// ===== sim.f =====
rtl/sm3_pkg.sv
rtl/sm3_round.sv
rtl/sm3_hash_engine_top.sv
tb/tb.sv
